// ===== src/tfei_pkg.sv =====
// Shared types, constants and helper functions of the trajectory fuel/energy integrator.
`default_nettype none
package tfei_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int SAMPLE_INDEX_BITS_DEF = 16;
	localparam int AMAG_W = 41;
	localparam int DIV_STEPS = 64;
	localparam int ENERGY_MIN_N = 4;
	localparam int FUEL_MIN_N = 3;

	localparam logic [2:0] REG_TIME_STEP = 3'd0;
	localparam logic [2:0] REG_CRUISE0 = 3'd1;
	localparam logic [2:0] REG_CRUISE1 = 3'd2;
	localparam logic [2:0] REG_CRUISE2 = 3'd3;
	localparam logic [2:0] REG_CRUISE3 = 3'd4;
	localparam logic [2:0] REG_ACCEL0 = 3'd5;
	localparam logic [2:0] REG_ACCEL1 = 3'd6;
	localparam logic [2:0] REG_ACCEL2 = 3'd7;

	localparam logic [15:0] TS_RESET = 16'd6554;
	// ceil(2^64 / 3): exact floor division by three for dividends below 2^63
	localparam logic [63:0] RECIP_THREE = 64'h5555_5555_5555_5556;
	localparam logic [6:0] SH_NONE = 7'd0;
	localparam logic [6:0] SH_Q8 = 7'd8;
	localparam logic [6:0] SH_Q16 = 7'd16;
	localparam logic [6:0] SH_Q24 = 7'd24;
	localparam logic [6:0] SH_RECIP = 7'd64;
	localparam logic [63:0] MAG_LIM = 64'h4000_0000_0000_0000;
	localparam logic signed [63:0] V48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] V48_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [4:0] {
		S_IDLE, S_DIV, S_EN, S_C1, S_UU, S_C2, S_UUU, S_C3, S_A1, S_A2, S_AT,
		S_PUSH, S_EP, S_ED, S_ET, S_FP, S_FD, S_FT, S_TOT
	} seq_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;     // two's complement multiplicand
		logic [63:0] b;     // unsigned multiplier
		logic [6:0]  sh;    // right shift of the exact product
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;   // two's complement, magnitude clamped
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
		if (v > V48_MAX) begin
			return V48_MAX[47:0];
		end
		if (v < V48_MIN) begin
			return V48_MIN[47:0];
		end
		return v[47:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/trajectory_fuel_energy_integrator.sv =====
// Top level: APB registers, sample sequencer, Simpson integration and running totals.
// First sample of a trajectory only seeds the previous speed. Each later sample takes a
// divide for the acceleration, six to nine multiplies and a push step before the next is accepted.
// The last sample adds up to six multiplies (divide by three by reciprocal) and a
// result load, stretched while the result register is held.
// arst_n clears the index, panel sums, totals; sets time_step to 6554, coefficients to 0.
`default_nettype none
module trajectory_fuel_energy_integrator #(
	parameter int SAMPLE_INDEX_BITS = tfei_pkg::SAMPLE_INDEX_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tfei_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [tfei_pkg::DATA_W-1:0]   pwdata,
	output      logic [tfei_pkg::DATA_W-1:0]   prdata,
	output      logic                          pready,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [15:0]                   speed_sample,
	input  wire logic                          last_sample,
	input  wire logic signed [15:0]            trajectory_delay,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic signed [47:0]            energy_value,
	output      logic signed [47:0]            fuel_value,
	output      logic signed [63:0]            delay_total,
	output      logic signed [63:0]            energy_total,
	output      logic signed [63:0]            fuel_total,
	output      logic [31:0]                   trajectories_counted
);
	import tfei_pkg::*;

	localparam logic [SAMPLE_INDEX_BITS-1:0] IDX_MAX = '1;

	// configuration registers
	logic [15:0]        ts_q;
	logic signed [31:0] cc0_q, cc1_q, cc2_q, cc3_q, ac0_q, ac1_q, ac2_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;
	logic [15:0]        ts_eff;

	// sequencer and per-trajectory state
	seq_state_t              state_q, state_d;
	logic                    issued_q;
	logic [SAMPLE_INDEX_BITS-1:0] idx_q;
	logic [15:0]             prev_q, cur_q, dm_q;
	logic                    last_q, pos_q;
	logic signed [15:0]      delay_q;
	logic [AMAG_W-1:0]       amag_q;
	logic signed [47:0]      e_q;
	logic signed [63:0]      f_q, t_q;
	logic [31:0]             uu_q;
	logic [47:0]             uuu_q;
	logic signed [63:0]      ep_q, fp_q;
	logic signed [47:0]      er0_q, er1_q, fr0_q, fr1_q;
	logic                    qneg_q;
	logic [63:0]             qmag_q;
	logic signed [63:0]      evs_q, fvs_q;

	// result register
	logic                    out_valid_q;
	logic signed [47:0]      ev_out_q, fv_out_q;
	logic signed [63:0]      dtot_q, etot_q, ftot_q;
	logic [31:0]             cnt_q;
	logic                    out_free;

	// shared units
	mul_req_t           mul_req;
	mul_rsp_t           mul_rsp;
	div_req_t           div_req;
	logic               div_done;
	logic [63:0]        div_quo;
	logic signed [63:0] mres, mhalf, qsigned;
	logic signed [47:0] ev48, fv48, fcl;
	logic               accel_on;

	tfei_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	tfei_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// APB register file: word address picks the register
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign ts_eff  = (ts_q == 16'd0) ? 16'd1 : ts_q;

	always_comb begin
		case (reg_idx)
			REG_TIME_STEP: prdata = {16'd0, ts_q};
			REG_CRUISE0:   prdata = cc0_q;
			REG_CRUISE1:   prdata = cc1_q;
			REG_CRUISE2:   prdata = cc2_q;
			REG_CRUISE3:   prdata = cc3_q;
			REG_ACCEL0:    prdata = ac0_q;
			REG_ACCEL1:    prdata = ac1_q;
			REG_ACCEL2:    prdata = ac2_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= TS_RESET;
			cc0_q <= '0;
			cc1_q <= '0;
			cc2_q <= '0;
			cc3_q <= '0;
			ac0_q <= '0;
			ac1_q <= '0;
			ac2_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TIME_STEP: ts_q  <= pwdata[15:0];
				REG_CRUISE0:   cc0_q <= pwdata;
				REG_CRUISE1:   cc1_q <= pwdata;
				REG_CRUISE2:   cc2_q <= pwdata;
				REG_CRUISE3:   cc3_q <= pwdata;
				REG_ACCEL0:    ac0_q <= pwdata;
				REG_ACCEL1:    ac1_q <= pwdata;
				REG_ACCEL2:    ac2_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign mres     = $signed(mul_rsp.res);
	// halve toward zero for the trapezoid term
	assign mhalf    = mres[63] ? -((-mres) >>> 1) : (mres >>> 1);
	// reapply the sign to the magnitude divided by three
	assign qsigned  = qneg_q ? -mres : mres;
	assign ev48     = clamp48(evs_q);
	assign fv48     = clamp48(fvs_q);
	assign fcl      = clamp48(f_q);
	assign accel_on = pos_q && (amag_q != '0);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// next state and requests to the shared units
	always_comb begin
		state_d = state_q;
		mul_req = '0;
		div_req = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (idx_q == '0 || idx_q == IDX_MAX) begin
						state_d = last_sample ? S_EP : S_IDLE;
					end else begin
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				div_req.start    = !issued_q;
				div_req.dividend = {24'd0, dm_q, 24'd0};
				div_req.divisor  = ts_eff;
				if (div_done) state_d = S_EN;
			end
			S_EN: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(amag_q);
				mul_req.b     = 64'(amag_q);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_C1;
			end
			S_C1: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(cc1_q);
				mul_req.b     = 64'(prev_q);
				mul_req.sh    = SH_Q8;
				if (mul_rsp.done) state_d = S_UU;
			end
			S_UU: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(prev_q);
				mul_req.b     = 64'(prev_q);
				mul_req.sh    = SH_NONE;
				if (mul_rsp.done) state_d = S_C2;
			end
			S_C2: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(cc2_q);
				mul_req.b     = 64'(uu_q);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_UUU;
			end
			S_UUU: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(uu_q);
				mul_req.b     = 64'(prev_q);
				mul_req.sh    = SH_NONE;
				if (mul_rsp.done) state_d = S_C3;
			end
			S_C3: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(cc3_q);
				mul_req.b     = 64'(uuu_q);
				mul_req.sh    = SH_Q24;
				if (mul_rsp.done) state_d = accel_on ? S_A1 : S_PUSH;
			end
			S_A1: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(ac1_q);
				mul_req.b     = 64'(prev_q);
				mul_req.sh    = SH_Q8;
				if (mul_rsp.done) state_d = S_A2;
			end
			S_A2: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(ac2_q);
				mul_req.b     = 64'(uu_q);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_AT;
			end
			S_AT: begin
				mul_req.start = !issued_q;
				mul_req.a     = t_q;
				mul_req.b     = 64'(amag_q);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_PUSH;
			end
			S_PUSH: begin
				state_d = last_q ? S_EP : S_IDLE;
			end
			S_EP: begin
				if (idx_q < SAMPLE_INDEX_BITS'(ENERGY_MIN_N)) begin
					state_d = S_FP;
				end else begin
					mul_req.start = !issued_q;
					mul_req.a     = ep_q;
					mul_req.b     = 64'(ts_eff);
					mul_req.sh    = SH_Q16;
					if (mul_rsp.done) state_d = S_ED;
				end
			end
			S_ED: begin
				mul_req.start = !issued_q;
				mul_req.a     = qmag_q;
				mul_req.b     = RECIP_THREE;
				mul_req.sh    = SH_RECIP;
				if (mul_rsp.done) state_d = idx_q[0] ? S_ET : S_FP;
			end
			S_ET: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(er0_q) + 64'(er1_q);
				mul_req.b     = 64'(ts_eff);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_FP;
			end
			S_FP: begin
				if (idx_q < SAMPLE_INDEX_BITS'(FUEL_MIN_N)) begin
					state_d = S_TOT;
				end else begin
					mul_req.start = !issued_q;
					mul_req.a     = fp_q;
					mul_req.b     = 64'(ts_eff);
					mul_req.sh    = SH_Q16;
					if (mul_rsp.done) state_d = S_FD;
				end
			end
			S_FD: begin
				mul_req.start = !issued_q;
				mul_req.a     = qmag_q;
				mul_req.b     = RECIP_THREE;
				mul_req.sh    = SH_RECIP;
				if (mul_rsp.done) state_d = idx_q[0] ? S_FT : S_TOT;
			end
			S_FT: begin
				mul_req.start = !issued_q;
				mul_req.a     = 64'(fr0_q) + 64'(fr1_q);
				mul_req.b     = 64'(ts_eff);
				mul_req.sh    = SH_Q16;
				if (mul_rsp.done) state_d = S_TOT;
			end
			S_TOT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_rsp.done || div_done) begin
				issued_q <= 1'b0;
			end else if (mul_req.start || div_req.start) begin
				issued_q <= 1'b1;
			end
		end
	end

	// per-trajectory datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			idx_q  <= '0;
			ep_q   <= '0;
			fp_q   <= '0;
			er0_q  <= '0;
			er1_q  <= '0;
			fr0_q  <= '0;
			fr1_q  <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q  <= last_sample;
						delay_q <= trajectory_delay;
						cur_q   <= speed_sample;
						pos_q   <= speed_sample > prev_q;
						dm_q    <= (speed_sample > prev_q) ? (speed_sample - prev_q)
							: (prev_q - speed_sample);
						// first sample only seeds the previous speed
						if (idx_q == '0) begin
							prev_q <= speed_sample;
							idx_q  <= SAMPLE_INDEX_BITS'(1);
						end
					end
				end
				S_DIV: if (div_done) amag_q <= div_quo[AMAG_W-1:0];
				S_EN:  if (mul_rsp.done) e_q <= clamp48(mres);
				S_C1:  if (mul_rsp.done) f_q <= sat_add(64'(cc0_q), mres);
				S_UU:  if (mul_rsp.done) uu_q <= mul_rsp.res[31:0];
				S_C2:  if (mul_rsp.done) f_q <= sat_add(f_q, mres);
				S_UUU: if (mul_rsp.done) uuu_q <= mul_rsp.res[47:0];
				S_C3:  if (mul_rsp.done) f_q <= sat_add(f_q, mres);
				S_A1:  if (mul_rsp.done) t_q <= sat_add(64'(ac0_q), mres);
				S_A2:  if (mul_rsp.done) t_q <= sat_add(t_q, mres);
				S_AT:  if (mul_rsp.done) f_q <= sat_add(f_q, mres);
				S_PUSH: begin
					// close a Simpson panel on every even value index from two on
					if (idx_q >= SAMPLE_INDEX_BITS'(3) && idx_q[0]) begin
						ep_q <= sat_add(ep_q, 64'(er1_q) + (64'(er0_q) <<< 2) + 64'(e_q));
						fp_q <= sat_add(fp_q, 64'(fr1_q) + (64'(fr0_q) <<< 2) + 64'(fcl));
					end
					er1_q  <= er0_q;
					er0_q  <= e_q;
					fr1_q  <= fr0_q;
					fr0_q  <= fcl;
					prev_q <= cur_q;
					idx_q  <= idx_q + SAMPLE_INDEX_BITS'(1);
				end
				S_EP: begin
					if (idx_q < SAMPLE_INDEX_BITS'(ENERGY_MIN_N)) begin
						evs_q <= '0;
					end else if (mul_rsp.done) begin
						qneg_q <= mul_rsp.res[63];
						qmag_q <= mres[63] ? 64'(-mres) : mul_rsp.res;
					end
				end
				S_ED: if (mul_rsp.done) evs_q <= qsigned;
				S_ET: if (mul_rsp.done) evs_q <= evs_q + mhalf;
				S_FP: begin
					if (idx_q < SAMPLE_INDEX_BITS'(FUEL_MIN_N)) begin
						fvs_q <= '0;
					end else if (mul_rsp.done) begin
						qneg_q <= mul_rsp.res[63];
						qmag_q <= mres[63] ? 64'(-mres) : mul_rsp.res;
					end
				end
				S_FD: if (mul_rsp.done) fvs_q <= qsigned;
				S_FT: if (mul_rsp.done) fvs_q <= fvs_q + mhalf;
				S_TOT: begin
					// drop the trajectory once its result is loaded
					if (out_free) begin
						prev_q <= '0;
						idx_q  <= '0;
						ep_q   <= '0;
						fp_q   <= '0;
						er0_q  <= '0;
						er1_q  <= '0;
						fr0_q  <= '0;
						fr1_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dtot_q      <= '0;
			etot_q      <= '0;
			ftot_q      <= '0;
			cnt_q       <= '0;
		end else if (state_q == S_TOT && out_free) begin
			out_valid_q <= 1'b1;
			ev_out_q    <= ev48;
			fv_out_q    <= fv48;
			dtot_q      <= sat_add(dtot_q, 64'(delay_q));
			etot_q      <= sat_add(etot_q, 64'(ev48));
			ftot_q      <= sat_add(ftot_q, 64'(fv48));
			if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign energy_value         = ev_out_q;
	assign fuel_value           = fv_out_q;
	assign delay_total          = dtot_q;
	assign energy_total         = etot_q;
	assign fuel_total           = ftot_q;
	assign trajectories_counted = cnt_q;

`ifndef ASSERT_OFF
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.busy && div_req.start) && !(mul_req.start && div_req.start))
		else $error("multiplier and divider started together");
	a_result_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_TOT)
		else $error("result appeared outside the closing step");
	a_traj_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOT && out_free) |=> (idx_q == '0 && ep_q == '0 && fp_q == '0))
		else $error("trajectory state not cleared after result");
	a_idle_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOT && out_free) |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== src/tfei_mul.sv =====
// Shared multiply unit: 32x32 partial products accumulated over four passes.
`default_nettype none
module tfei_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tfei_pkg::mul_req_t req,
	output      tfei_pkg::mul_rsp_t rsp
);
	import tfei_pkg::*;

	logic [63:0]  am_q, bm_q;
	logic         neg_q;
	logic [6:0]   sh_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   off_s1;
	logic         ppv_s1;
	logic [127:0] acc_q;
	logic [63:0]  res_q;

	logic [63:0]  a_abs;
	logic [31:0]  a_half, b_half;
	logic [127:0] pp_ext, shifted;
	logic [63:0]  mag, res_c;

	assign a_abs  = req.a[63] ? (~req.a + 64'd1) : req.a;
	assign a_half = cnt_q[1] ? am_q[63:32] : am_q[31:0];
	assign b_half = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];

	always_comb begin
		case (off_s1)
			2'd0: pp_ext = {64'd0, pp_s1};
			2'd1: pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2: pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
		shifted = acc_q >> sh_q;
		mag     = (shifted > {64'd0, MAG_LIM}) ? MAG_LIM : shifted[63:0];
		res_c   = neg_q ? (~mag + 64'd1) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
			if (req.start) begin
				am_q   <= a_abs;
				neg_q  <= req.a[63];
				bm_q   <= req.b;
				sh_q   <= req.sh;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q <= 3'd3) begin
					pp_s1  <= a_half * b_half;
					off_s1 <= {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]};
					ppv_s1 <= 1'b1;
				end
				if (ppv_s1) begin
					acc_q <= acc_q + pp_ext;
				end
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					res_q  <= res_c;
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp = {busy_q, done_q, res_q};

endmodule
`default_nettype wire

// ===== src/tfei_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tfei_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tfei_pkg::div_req_t req,
	output      logic               done,
	output      logic [63:0]        quo
);
	import tfei_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      quo_q;
	logic [15:0]      rem_q, dsr_q;
	logic [16:0]      trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[62:0], ge};
				rem_q <= ge ? diff[15:0] : trial[15:0];
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== bench/trajectory_fuel_energy_integrator_tb.sv =====
// Self-checking testbench for the trajectory fuel and energy integrator.
`timescale 1ns / 100ps
`default_nettype none
module trajectory_fuel_energy_integrator_tb;
	import tfei_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam longint L48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint L48_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;
	localparam longint L64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint L64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [127:0] PROD_LIM = 128'h4000_0000_0000_0000;

	typedef struct {
		logic [47:0] energy;
		logic [47:0] fuel;
		logic [63:0] delay_sum;
		logic [63:0] energy_sum;
		logic [63:0] fuel_sum;
		logic [31:0] count;
	} trajectory_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] speed_sample = '0;
	logic last_sample = 1'b0;
	logic signed [15:0] trajectory_delay = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [47:0] energy_value, fuel_value;
	logic signed [63:0] delay_total, energy_total, fuel_total;
	logic [31:0] trajectories_counted;

	trajectory_fuel_energy_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.speed_sample(speed_sample), .last_sample(last_sample),
		.trajectory_delay(trajectory_delay),
		.out_valid(out_valid), .out_ready(out_ready),
		.energy_value(energy_value), .fuel_value(fuel_value),
		.delay_total(delay_total), .energy_total(energy_total),
		.fuel_total(fuel_total), .trajectories_counted(trajectories_counted)
	);

	always #5 clk = ~clk;

	// Mirror of the block: configuration, per-trajectory state and running totals.
	logic [15:0] m_step;
	logic [31:0] m_coef [1:7];
	logic [15:0] m_prev;
	int unsigned m_index;
	longint m_e_panel, m_f_panel;
	longint m_e_recent [2];
	longint m_f_recent [2];
	longint m_delay_acc, m_energy_acc, m_fuel_acc;
	logic [31:0] m_count;

	trajectory_result_t pending_results [$];
	int mismatches = 0;
	int unsigned cycles = 0;
	bit idle_on = 1'b0;
	bit long_hold_req = 1'b0;

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? L64_MIN : L64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic longint sat48(longint v);
		if (v > L48_MAX) begin
			return L48_MAX;
		end
		if (v < L48_MIN) begin
			return L48_MIN;
		end
		return v;
	endfunction

	// Exact product shifted down, truncated toward zero, magnitude clamped to 2^62.
	function automatic longint scaled_product(longint a, logic [63:0] b, int sh);
		logic [63:0] mag;
		logic [127:0] p;
		logic neg;
		neg = a < 0;
		mag = neg ? -a : a;
		p = ({64'd0, mag} * {64'd0, b}) >> sh;
		if (p > PROD_LIM) begin
			p = PROD_LIM;
		end
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic logic [63:0] eff_step();
		return (m_step == 16'd0) ? 64'd1 : {48'd0, m_step};
	endfunction

	function automatic longint coef(int i);
		return longint'(signed'(m_coef[i]));
	endfunction

	function automatic longint simpson(longint panel, longint r0, longint r1, int unsigned n,
		int unsigned least);
		longint v;
		if (n < least) begin
			return 0;
		end
		v = scaled_product(panel, eff_step(), 16) / 3;
		if (((n - 1) & 1) == 0) begin
			v += scaled_product(r0 + r1, eff_step(), 16) / 2;
		end
		return sat48(v);
	endfunction

	task automatic clear_trajectory();
		m_prev = '0;
		m_index = 0;
		m_e_panel = 0;
		m_f_panel = 0;
		m_e_recent = '{0, 0};
		m_f_recent = '{0, 0};
	endtask

	task automatic absorb_speed(logic [15:0] cur);
		longint diff, e, f, t;
		logic [63:0] dm, amag, u;
		int unsigned k;
		if (m_index > 0) begin
			u = {48'd0, m_prev};
			diff = longint'(cur) - longint'(m_prev);
			dm = diff < 0 ? -diff : diff;
			amag = (dm << 24) / eff_step();
			k = m_index - 1;
			e = sat48(scaled_product(amag, amag, 16));
			f = coef(REG_CRUISE0);
			f = add_sat(f, scaled_product(coef(REG_CRUISE1), u, 8));
			f = add_sat(f, scaled_product(coef(REG_CRUISE2), u * u, 16));
			f = add_sat(f, scaled_product(coef(REG_CRUISE3), u * u * u, 24));
			// acceleration term only counts while speeding up
			if (diff > 0 && amag != 0) begin
				t = coef(REG_ACCEL0);
				t = add_sat(t, scaled_product(coef(REG_ACCEL1), u, 8));
				t = add_sat(t, scaled_product(coef(REG_ACCEL2), u * u, 16));
				f = add_sat(f, scaled_product(t, amag, 16));
			end
			f = sat48(f);
			// close a Simpson panel on every even point past the first pair
			if (k >= 2 && (k & 1) == 0) begin
				m_e_panel = add_sat(m_e_panel, m_e_recent[1] + 4 * m_e_recent[0] + e);
				m_f_panel = add_sat(m_f_panel, m_f_recent[1] + 4 * m_f_recent[0] + f);
			end
			m_e_recent[1] = m_e_recent[0];
			m_e_recent[0] = e;
			m_f_recent[1] = m_f_recent[0];
			m_f_recent[0] = f;
		end
		m_prev = cur;
		m_index++;
	endtask

	// Advance the mirror by one request; queue the result if it closes a trajectory.
	task automatic predict_trajectory(logic [15:0] spd, logic last, logic signed [15:0] dly);
		trajectory_result_t r;
		longint ev, fv;
		if (m_index < (2 ** SAMPLE_INDEX_BITS_DEF) - 1) begin
			absorb_speed(spd);
		end
		if (last) begin
			ev = simpson(m_e_panel, m_e_recent[0], m_e_recent[1], m_index, ENERGY_MIN_N);
			fv = simpson(m_f_panel, m_f_recent[0], m_f_recent[1], m_index, FUEL_MIN_N);
			m_delay_acc = add_sat(m_delay_acc, longint'(dly));
			m_energy_acc = add_sat(m_energy_acc, ev);
			m_fuel_acc = add_sat(m_fuel_acc, fv);
			if (m_count != 32'hFFFF_FFFF) begin
				m_count++;
			end
			r.energy = ev[47:0];
			r.fuel = fv[47:0];
			r.delay_sum = m_delay_acc;
			r.energy_sum = m_energy_acc;
			r.fuel_sum = m_fuel_acc;
			r.count = m_count;
			pending_results = {pending_results, r};
			clear_trajectory();
		end
	endtask

	// Write one register through the APB port and mirror it.
	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (idx == REG_TIME_STEP) begin
			m_step = value[15:0];
		end else begin
			m_coef[idx] = value;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic load_config(logic [15:0] ts, logic [31:0] c0, logic [31:0] c1,
		logic [31:0] c2, logic [31:0] c3, logic [31:0] a0, logic [31:0] a1, logic [31:0] a2);
		reg_write(REG_TIME_STEP, {16'd0, ts});
		reg_write(REG_CRUISE0, c0);
		reg_write(REG_CRUISE1, c1);
		reg_write(REG_CRUISE2, c2);
		reg_write(REG_CRUISE3, c3);
		reg_write(REG_ACCEL0, a0);
		reg_write(REG_ACCEL1, a1);
		reg_write(REG_ACCEL2, a2);
	endtask

	// Offer one speed request; hold it until the block takes it.
	task automatic send_speed(logic [15:0] spd, logic last, logic signed [15:0] dly);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		speed_sample = spd;
		last_sample = last;
		trajectory_delay = dly;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_trajectory(spd, last, dly);
	endtask

	// Let every queued result arrive, then cover an in-flight non-closing sample.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_step();
		case ($urandom_range(0, 4))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd0;
			default: return 16'($urandom_range(1, 16'hFFFF));
		endcase
	endfunction

	// One trajectory: mostly smooth speeds, sometimes wild jumps.
	task automatic random_trajectory(int len, ref int sent);
		logic [15:0] spd;
		int step;
		bit wild;
		wild = $urandom_range(0, 3) == 0;
		spd = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			if (wild) begin
				spd = 16'($urandom);
			end else begin
				step = int'(spd) + $urandom_range(0, 1024) - 512;
				spd = step < 0 ? 16'd0 : (step > 65535 ? 16'hFFFF : step[15:0]);
			end
			send_speed(spd, i == len - 1, 16'($urandom));
			sent++;
		end
	endtask

	task automatic test_short_trajectories();
		load_config(16'd6554, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_F000, 32'h0000_0010,
			32'h0002_0000, 32'hFFFF_8000, 32'h0000_0100);
		// lengths one through five straddle both minimum-count thresholds
		for (int len = 1; len <= 5; len++) begin
			for (int i = 0; i < len; i++) begin
				send_speed((i % 2) ? 16'hFFFF : 16'h0000, i == len - 1,
					(len % 2) ? 16'sh7FFF : -16'sh8000);
			end
		end
		drain();
	endtask

	task automatic test_saturation();
		// tiny step and full-scale jumps push products into clamping
		load_config(16'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_speed(16'h0000, 1'b0, 16'sd0);
		send_speed(16'hFFFF, 1'b0, 16'sd0);
		send_speed(16'h0000, 1'b0, 16'sd0);
		send_speed(16'hFFFF, 1'b0, 16'sd0);
		send_speed(16'hFFFF, 1'b1, -16'sd1);
		drain();
		load_config(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_speed(16'hFFFF, 1'b0, 16'sd0);
		send_speed(16'h0001, 1'b0, 16'sd0);
		send_speed(16'hFFFF, 1'b0, 16'sd0);
		send_speed(16'h8000, 1'b1, 16'sd1);
		drain();
	endtask

	task automatic test_zero_step();
		// a zero time step must act as one
		reg_write(REG_TIME_STEP, 32'd0);
		send_speed(16'h0100, 1'b0, 16'sd0);
		send_speed(16'h0200, 1'b0, 16'sd0);
		send_speed(16'h0180, 1'b1, 16'sd100);
		drain();
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		int sent;
		for (int p = 0; p < phases; p++) begin
			load_config(rand_step(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef(), rand_coef(), rand_coef());
			sent = 0;
			while (sent < per_phase) begin
				random_trajectory(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12), sent);
			end
			drain();
		end
	endtask

	task automatic test_output_backpressure();
		int sent;
		sent = 0;
		long_hold_req = 1'b1;
		// keep offering short trajectories while the receiver holds off
		while (sent < 40) begin
			random_trajectory($urandom_range(1, 3), sent);
		end
		drain();
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 3000;
			end else if (hold == 0 && idle_on && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 16);
			end
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = arst_n;
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		trajectory_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: energy %h fuel %h", energy_value, fuel_value);
				end
			end else begin
				exp_r = pending_results.pop_front();
				if (energy_value !== exp_r.energy || fuel_value !== exp_r.fuel
					|| delay_total !== exp_r.delay_sum || energy_total !== exp_r.energy_sum
					|| fuel_total !== exp_r.fuel_sum || trajectories_counted !== exp_r.count)
				begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp e=%h f=%h d=%h et=%h ft=%h n=%h",
							exp_r.energy, exp_r.fuel, exp_r.delay_sum, exp_r.energy_sum,
							exp_r.fuel_sum, exp_r.count);
						$display("         got e=%h f=%h d=%h et=%h ft=%h n=%h",
							energy_value, fuel_value, delay_total, energy_total,
							fuel_total, trajectories_counted);
					end
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		m_step = TS_RESET;
		for (int i = 1; i <= 7; i++) begin
			m_coef[i] = '0;
		end
		clear_trajectory();
		m_delay_acc = 0;
		m_energy_acc = 0;
		m_fuel_acc = 0;
		m_count = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_short_trajectories();
		test_saturation();
		test_zero_step();
		idle_on = 1'b1;
		test_random_phases(4, 120);
		test_output_backpressure();
		// last stretch runs with no idling on either side
		idle_on = 1'b0;
		test_random_phases(1, 80);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
